### rtl/mcht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcht_pkg
// shared types and codes for the monotone convex hull trick block
// ----------------------------------------------------------------------------
package mcht_pkg;

   localparam int unsigned SLOPE_W = 32;
   localparam int unsigned ICPT_W  = 64;
   localparam int unsigned X_W     = 32;
   localparam int unsigned VALUE_W = 64;
   localparam int unsigned MAG_W   = 96;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_ADD   = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_BAD_SLOPE = 2'd3
   } status_type;

   typedef struct packed {
      logic [ICPT_W-1:0]  intercept;
      logic [SLOPE_W-1:0] slope;
   } line_type;

   // memory port controls from the sequencer
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

endpackage

### rtl/mcht_line_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcht_line_mem
// line store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module mcht_line_mem #(
   parameter int unsigned DEPTH = 1024,
   parameter int unsigned AW    = 10
) (
   input  logic               clock,
   input  mcht_pkg::mem_ctl_type ctl,
   input  logic [AW-1:0]      rd_addr,
   output mcht_pkg::line_type rd_data,
   input  logic [AW-1:0]      wr_addr,
   input  mcht_pkg::line_type wr_data
);
   import mcht_pkg::*;

   line_type mem [DEPTH];
   line_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/monotone_convex_hull_trick.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// monotone_convex_hull_trick
// deque of lines -s*x + c in a ring memory, maximum queries with front pops
// ----------------------------------------------------------------------------
// One item at a time. Clear, unused commands, and an add to an empty hull
// answer in the cycle after the word is taken; a rejected add answers once
// the back line is read; an accepted add examines back lines in turn (after
// a pop, the old second-to-back line is reused, so one read is shared with
// the next examination); a query examines front lines in turn. The
// per-pop cost is set by the single read port of the line memory and the one
// 32x32 multiplier, which forms each 64x32 cross product in two halves.
// No clearing pass: entries outside the live window are never read.
module monotone_convex_hull_trick #(
   parameter int unsigned HULL_DEPTH = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // slope[31:0], intercept[95:32], query_x[127:96]
   input  logic [1:0]   req_tuser,   // cmd[1:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [71:0]  rsp_tdata    // value[63:0], status[65:64], zero[71:66]
);
   import mcht_pkg::*;

   localparam int unsigned AW = $clog2(HULL_DEPTH);
   localparam int unsigned CW = $clog2(HULL_DEPTH + 1);

   typedef enum logic [11:0] {
      S_IDLE  = 12'b000000000001,
      S_A_RD1 = 12'b000000000010,
      S_A_RD0 = 12'b000000000100,
      S_A_MUL = 12'b000000001000,
      S_A_ACC = 12'b000000010000,
      S_A_CMP = 12'b000000100000,
      S_Q_RD0 = 12'b000001000000,
      S_Q_RD1 = 12'b000010000000,
      S_Q_MUL = 12'b000100000000,
      S_Q_CMP = 12'b001000000000,
      S_Q_VAL = 12'b010000000000,
      S_Q_SAT = 12'b100000000000
   } state_type;

   function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] front,
                                              input logic [CW-1:0] idx);
      logic [CW:0] sum;
      sum = (CW+1)'(front) + (CW+1)'(idx);
      if (sum >= (CW+1)'(HULL_DEPTH)) begin
         sum = sum - (CW+1)'(HULL_DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   function automatic logic [64:0] sdiff(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] d;
      logic [63:0] mag;
      d = {a[63], a} - {b[63], b};
      mag = d[64] ? (64'd0 - d[63:0]) : d[63:0];
      return {d[64], mag};
   endfunction

   state_type        state_ff, state_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [AW-1:0]    front_ff, front_in;
   logic [1:0]       step_ff, step_in;
   logic [31:0]      sn_ff, sn_in, x_ff, x_in;
   logic [63:0]      cn_ff, cn_in;
   line_type         l0_ff, l0_in, l1_ff, l1_in;
   logic [63:0]      ml_ff, ml_in, mr_ff, mr_in;
   logic             nl_ff, nl_in, nr_ff, nr_in;
   logic [31:0]      dsl_ff, dsl_in, dsr_ff, dsr_in;
   logic [MAG_W-1:0] pl_ff, pl_in, pr_ff, pr_in;
   logic [63:0]      prod_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [63:0]      rsp_value_ff, rsp_value_in;
   status_type       rsp_status_ff, rsp_status_in;

   mem_ctl_type      mctl;
   logic [AW-1:0]    rd_addr, wr_addr;
   line_type         rd_data, wr_data;
   logic [31:0]      mul_a, mul_b;
   logic             req_fire, slot_free;
   cmd_type          req_cmd;
   logic [64:0]      dl, dr, dq;
   logic             le_ok, sl, sr, ltm;
   logic [65:0]      vres;

   mcht_line_mem #(.DEPTH(HULL_DEPTH), .AW(AW)) u_mem (
      .clock   (clock),
      .ctl     (mctl),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && slot_free;
   assign req_fire   = req_tvalid && req_tready;
   assign req_cmd    = cmd_type'(req_tuser);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_status_ff, rsp_value_ff};

   // shared multiplier, one product per cycle
   always_comb begin
      mul_a = dsl_ff;
      mul_b = ml_ff[31:0];
      case (state_ff)
         S_A_MUL: begin
            mul_a = step_ff[1] ? dsr_ff : dsl_ff;
            case (step_ff)
               2'd0:    mul_b = ml_ff[31:0];
               2'd1:    mul_b = ml_ff[63:32];
               2'd2:    mul_b = mr_ff[31:0];
               default: mul_b = mr_ff[63:32];
            endcase
         end
         S_Q_MUL: begin
            mul_a = dsl_ff;
            mul_b = x_ff;
         end
         S_Q_VAL: begin
            mul_a = l0_ff.slope;
            mul_b = x_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= 64'(mul_a) * 64'(mul_b);
   end

   // signed-magnitude compare of the two cross products
   always_comb begin
      sl  = nl_ff && (pl_ff != '0);
      sr  = nr_ff && (pr_ff != '0);
      ltm = pl_ff < pr_ff;
      if (sl != sr) begin
         le_ok = sl;
      end else if (!sl) begin
         le_ok = ltm || (pl_ff == pr_ff);
      end else begin
         le_ok = !ltm;
      end
   end

   assign dl   = sdiff(l1_ff.intercept, rd_data.intercept);
   assign dr   = sdiff(cn_ff, l1_ff.intercept);
   assign dq   = sdiff(rd_data.intercept, l0_ff.intercept);
   assign vres = {{2{l0_ff.intercept[63]}}, l0_ff.intercept} - {2'b00, prod_ff};

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      front_in      = front_ff;
      step_in       = step_ff;
      sn_in         = sn_ff;
      cn_in         = cn_ff;
      x_in          = x_ff;
      l0_in         = l0_ff;
      l1_in         = l1_ff;
      ml_in         = ml_ff;
      mr_in         = mr_ff;
      nl_in         = nl_ff;
      nr_in         = nr_ff;
      dsl_in        = dsl_ff;
      dsr_in        = dsr_ff;
      pl_in         = pl_ff;
      pr_in         = pr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      mctl          = '0;
      rd_addr       = front_ff;
      wr_addr       = ring_pos(front_ff, cnt_ff);
      wr_data       = '{intercept: cn_ff, slope: sn_ff};

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               sn_in = req_tdata[31:0];
               cn_in = req_tdata[95:32];
               x_in  = req_tdata[127:96];
               rsp_value_in  = '0;
               rsp_status_in = ST_OK;
               case (req_cmd)
                  CMD_CLEAR: begin
                     cnt_in       = '0;
                     front_in     = '0;
                     rsp_valid_in = 1'b1;
                  end
                  CMD_ADD: begin
                     if (cnt_ff == '0) begin
                        mctl.wr_en   = 1'b1;
                        wr_data      = '{intercept: req_tdata[95:32], slope: req_tdata[31:0]};
                        cnt_in       = CW'(1);
                        rsp_valid_in = 1'b1;
                     end else begin
                        mctl.rd_en = 1'b1;
                        rd_addr    = ring_pos(front_ff, cnt_ff - CW'(1));
                        state_in   = S_A_RD1;
                     end
                  end
                  CMD_QUERY: begin
                     if (cnt_ff == '0) begin
                        rsp_status_in = ST_EMPTY;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        mctl.rd_en = 1'b1;
                        rd_addr    = front_ff;
                        state_in   = S_Q_RD0;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_A_RD1: begin
            l1_in = rd_data;
            if (sn_ff <= rd_data.slope) begin
               rsp_status_in = ST_BAD_SLOPE;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else if (cnt_ff >= CW'(HULL_DEPTH)) begin
               rsp_status_in = ST_FULL;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else if (cnt_ff < CW'(2)) begin
               mctl.wr_en   = 1'b1;
               cnt_in       = cnt_ff + CW'(1);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               mctl.rd_en = 1'b1;
               rd_addr    = ring_pos(front_ff, cnt_ff - CW'(2));
               state_in   = S_A_RD0;
            end
         end
         S_A_RD0: begin
            l0_in    = rd_data;
            nl_in    = dl[64];
            ml_in    = dl[63:0];
            nr_in    = dr[64];
            mr_in    = dr[63:0];
            dsl_in   = sn_ff - l1_ff.slope;
            dsr_in   = l1_ff.slope - rd_data.slope;
            step_in  = '0;
            state_in = S_A_MUL;
         end
         S_A_MUL: begin
            // partial products are registered, so each is read at the step after the one that formed it
            step_in = step_ff + 2'd1;
            case (step_ff)
               2'd1:    pl_in = MAG_W'(prod_ff);
               2'd2:    pl_in = pl_ff + {prod_ff, 32'd0};
               2'd3:    pr_in = MAG_W'(prod_ff);
               default: begin
               end
            endcase
            if (step_ff == 2'd3) begin
               state_in = S_A_ACC;
            end
         end
         S_A_ACC: begin
            pr_in    = pr_ff + {prod_ff, 32'd0};
            state_in = S_A_CMP;
         end
         S_A_CMP: begin
            if (le_ok) begin
               // back line is useless: drop it, old second-to-back becomes back
               l1_in = l0_ff;
               if (cnt_ff - CW'(1) >= CW'(2)) begin
                  cnt_in     = cnt_ff - CW'(1);
                  mctl.rd_en = 1'b1;
                  rd_addr    = ring_pos(front_ff, cnt_ff - CW'(3));
                  state_in   = S_A_RD0;
               end else begin
                  mctl.wr_en   = 1'b1;
                  wr_addr      = ring_pos(front_ff, cnt_ff - CW'(1));
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end else begin
               mctl.wr_en   = 1'b1;
               cnt_in       = cnt_ff + CW'(1);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_Q_RD0: begin
            l0_in = rd_data;
            if (cnt_ff >= CW'(2)) begin
               mctl.rd_en = 1'b1;
               rd_addr    = ring_pos(front_ff, CW'(1));
               state_in   = S_Q_RD1;
            end else begin
               state_in = S_Q_VAL;
            end
         end
         S_Q_RD1: begin
            l1_in    = rd_data;
            nl_in    = dq[64];
            ml_in    = dq[63:0];
            dsl_in   = rd_data.slope - l0_ff.slope;
            state_in = S_Q_MUL;
         end
         S_Q_MUL: begin
            state_in = S_Q_CMP;
         end
         S_Q_CMP: begin
            if ((nl_ff && ml_ff != '0) || ml_ff < prod_ff) begin
               state_in = S_Q_VAL;
            end else begin
               front_in = (front_ff == AW'(HULL_DEPTH - 1)) ? '0 : front_ff + AW'(1);
               cnt_in   = cnt_ff - CW'(1);
               l0_in    = l1_ff;
               if (cnt_ff - CW'(1) >= CW'(2)) begin
                  mctl.rd_en = 1'b1;
                  rd_addr    = ring_pos(front_ff, CW'(2));
                  state_in   = S_Q_RD1;
               end else begin
                  state_in = S_Q_VAL;
               end
            end
         end
         S_Q_VAL: begin
            state_in = S_Q_SAT;
         end
         S_Q_SAT: begin
            // clamp below the signed minimum
            if (vres[65] && vres[64:63] != 2'b11) begin
               rsp_value_in = 64'h8000_0000_0000_0000;
            end else begin
               rsp_value_in = vres[63:0];
            end
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         front_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         front_ff     <= front_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      sn_ff         <= sn_in;
      cn_ff         <= cn_in;
      x_ff          <= x_in;
      l0_ff         <= l0_in;
      l1_ff         <= l1_in;
      ml_ff         <= ml_in;
      mr_ff         <= mr_in;
      nl_ff         <= nl_in;
      nr_ff         <= nr_in;
      dsl_ff        <= dsl_in;
      dsr_ff        <= dsr_in;
      pl_ff         <= pl_in;
      pr_ff         <= pr_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

`ifndef NO_ASSERTIONS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(HULL_DEPTH))
      else $error("line count above depth");

   a_front_range: assert property (@(posedge clock) disable iff (reset)
      front_ff < AW'(HULL_DEPTH) || AW'(HULL_DEPTH) == '0)
      else $error("front index out of range");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_cmd == CMD_CLEAR |=> cnt_ff == '0 && front_ff == '0 && rsp_valid_ff)
      else $error("clear did not empty the hull");

   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_tready)
      else $error("word taken while busy");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(mctl.rd_en && mctl.wr_en))
      else $error("read and write in one cycle");
`endif

endmodule
